[rtl/core/block_peak_rms_meter_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the peak/RMS meter
// Shared concurrent assertion forms, all synchronous to the block clock and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BLOCK_PEAK_RMS_METER_MACROS_SVH
`define BLOCK_PEAK_RMS_METER_MACROS_SVH

// Same-cycle implication
`define BPRM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define BPRM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bprm_pkg.sv]
// ----------------------------------------------------------------------------
// bprm_pkg
// Widths and shared types of the block peak/RMS meter.
// ----------------------------------------------------------------------------
`default_nettype none

package bprm_pkg;

   localparam int SAMPLE_W   = 16;  // signed Q1.15 sample
   localparam int MAG_W      = 16;  // magnitude 0..32768
   localparam int SQ_W       = 31;  // square of a magnitude, up to 2^30
   localparam int ROOT_W     = 16;  // root of a value below 2^32
   localparam int RAD_W      = 32;  // radicand, mean padded to an even width
   localparam int SQ_REM_W   = 19;  // partial remainder of the root search

   // Status from the divide/root engine back to the top sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } bprm_iter_status_type;

endpackage

`default_nettype wire

[rtl/core/bprm_ifs.sv]
// ----------------------------------------------------------------------------
// bprm_ifs
// Valid/ready channels of the meter: sample requests and level responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface bprm_req_if import bprm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_in_block;

   modport source (output valid, output sample, output last_in_block, input ready);
   modport sink   (input valid, input sample, input last_in_block, output ready);
endinterface

interface bprm_rsp_if import bprm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MAG_W-1:0]  peak_level;
   logic [ROOT_W-1:0] rms_level;
   logic              overflow;

   modport source (output valid, output peak_level, output rms_level, output overflow,
                   input ready);
   modport sink   (input valid, input peak_level, input rms_level, input overflow,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/bprm_sub_unit.sv]
// ----------------------------------------------------------------------------
// bprm_sub_unit
// Shared compare-and-subtract unit used by both the divider and the root search.
// ----------------------------------------------------------------------------
`default_nettype none

module bprm_sub_unit #(
   parameter int W = 19
) (
   input  wire logic [W-1:0] op_a,
   input  wire logic [W-1:0] op_b,
   output logic              ge,
   output logic [W-1:0]      diff
);

   logic [W:0] wide;

   // One borrow chain gives both the difference and the compare
   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign diff = wide[W-1:0];
   assign ge   = ~wide[W];

endmodule

`default_nettype wire

[rtl/core/bprm_div_sqrt.sv]
// ----------------------------------------------------------------------------
// bprm_div_sqrt
// Iterative mean and root: restoring division sum/count, one quotient bit per
// cycle, then a digit-by-digit square root, one root bit per cycle, both on a
// single shared compare-subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bprm_div_sqrt import bprm_pkg::*; #(
   parameter int SUM_W = 43,
   parameter int CNT_W = 13
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SUM_W-1:0]  sum,
   input  wire logic [CNT_W-1:0]  count,
   output bprm_iter_status_type   status,
   output logic [ROOT_W-1:0]      root
);

   localparam int WK_W   = (SUM_W > RAD_W) ? SUM_W : RAD_W;
   localparam int UW     = (CNT_W + 1 > SQ_REM_W) ? CNT_W + 1 : SQ_REM_W;
   localparam int STEP_W = $clog2(WK_W);

   localparam logic [1:0] I_IDLE = 2'd0;
   localparam logic [1:0] I_DIV  = 2'd1;
   localparam logic [1:0] I_SQRT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [WK_W-1:0]   work_ff, work_in;     // dividend/quotient, then radicand
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [UW-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic              done_ff, done_in;

   logic [UW-1:0]     op_a, op_b, diff;
   logic              ge;

   // Operand select for the shared unit
   always_comb begin
      if (state_ff == I_SQRT) begin
         op_a = {rem_ff[UW-3:0], work_ff[RAD_W-1 -: 2]};
         op_b = UW'({root_ff, 2'b01});
      end else begin
         op_a = {rem_ff[UW-2:0], work_ff[WK_W-1]};
         op_b = UW'(divisor_ff);
      end
   end

   bprm_sub_unit #(.W(UW)) u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .ge   (ge),
      .diff (diff)
   );

   // Sequencer: divide over WK_W steps, then root over ROOT_W steps
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         I_IDLE: begin
            if (start) begin
               work_in    = WK_W'(sum);
               divisor_in = count;
               rem_in     = '0;
               step_in    = STEP_W'(WK_W - 1);
               state_in   = I_DIV;
            end
         end
         I_DIV: begin
            rem_in  = ge ? diff : op_a;
            work_in = {work_ff[WK_W-2:0], ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               // quotient stays below 2^31, so the low RAD_W bits are the radicand
               rem_in   = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W - 1);
               state_in = I_SQRT;
            end
         end
         I_SQRT: begin
            rem_in  = ge ? diff : op_a;
            root_in = {root_ff[ROOT_W-2:0], ge};
            work_in = {work_ff[WK_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = I_IDLE;
            end
         end
         default: state_in = I_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= I_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff    <= step_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
   end

   assign status.busy = (state_ff != I_IDLE);
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule

`default_nettype wire

[rtl/core/block_peak_rms_meter.sv]
// Each sample passes the transfer, square and accumulate steps; the ready goes low meanwhile.
// Block end: after the last sample's transfer the divider takes the sum one bit per cycle,
//   over WK_W = max(31 + clog2(MAX_BLOCK_SAMPLES), 32) bits, followed by the 16-step root
//   search on one subtractor; the result loads once the output register is empty or read.
// A finished result waits in the output register while the next block is taken in.
// Reset (synchronous, active high) clears the sequencer, accumulators and output valid.
// ----------------------------------------------------------------------------
// block_peak_rms_meter
// Per-block peak magnitude and RMS of Q1.15 samples, with saturating length
// accounting and an overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "block_peak_rms_meter_macros.svh"

module block_peak_rms_meter import bprm_pkg::*; #(
   parameter int MAX_BLOCK_SAMPLES = 4096
) (
   input  wire logic clock,
   input  wire logic reset,
   bprm_req_if.sink  req_chan,
   bprm_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int SUM_W = SQ_W + $clog2(MAX_BLOCK_SAMPLES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SQUARE = 3'd1;
   localparam logic [2:0] S_ADD    = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               last_ff, last_in;
   logic [SQ_W-1:0]    square_ff, square_in;
   logic [MAG_W-1:0]   peak_ff, peak_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               ovf_ff, ovf_in;
   logic [MAG_W-1:0]   hold_peak_ff, hold_peak_in;
   logic               hold_ovf_ff, hold_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAG_W-1:0]   out_peak_ff, out_peak_in;
   logic [ROOT_W-1:0]  out_rms_ff, out_rms_in;
   logic               out_ovf_ff, out_ovf_in;

   logic [MAG_W-1:0]   raw;
   logic [2*MAG_W-1:0] product;
   logic [SUM_W-1:0]   sum_next;
   logic [CNT_W-1:0]   count_next;
   logic               ovf_next;
   logic               accept;
   logic               load;
   logic               iter_start;
   logic [ROOT_W-1:0]  root;
   bprm_iter_status_type iter_status;

   assign accept = req_chan.valid & req_chan.ready;
   assign load   = (state_ff == S_OUT) & (~rsp_valid_ff | rsp_chan.ready);

   // Magnitude of the sample; the most negative code maps to 32768
   assign raw     = req_chan.sample;
   assign product = mag_ff * mag_ff;

   // Saturating accumulation: beyond the limit only the overflow flag moves
   always_comb begin
      if (count_ff < CNT_W'(MAX_BLOCK_SAMPLES)) begin
         sum_next   = sum_ff + SUM_W'(square_ff);
         count_next = count_ff + CNT_W'(1);
         ovf_next   = ovf_ff;
      end else begin
         sum_next   = sum_ff;
         count_next = count_ff;
         ovf_next   = 1'b1;
      end
   end

   // Top sequencer
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      square_in    = square_ff;
      peak_in      = peak_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      hold_peak_in = hold_peak_ff;
      hold_ovf_in  = hold_ovf_ff;
      iter_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mag_in   = raw[MAG_W-1] ? (~raw + MAG_W'(1)) : raw;
               last_in  = req_chan.last_in_block;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            square_in = product[SQ_W-1:0];
            if (mag_ff > peak_ff) begin
               peak_in = mag_ff;
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            sum_in   = sum_next;
            count_in = count_next;
            ovf_in   = ovf_next;
            state_in = S_IDLE;
            if (last_ff) begin
               // hand the totals to the engine and start the next block clean
               iter_start   = 1'b1;
               hold_peak_in = peak_ff;
               hold_ovf_in  = ovf_next;
               peak_in      = '0;
               sum_in       = '0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = S_WAIT;
            end
         end
         S_WAIT: begin
            if (iter_status.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   bprm_div_sqrt #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (iter_start),
      .sum    (sum_next),
      .count  (count_next),
      .status (iter_status),
      .root   (root)
   );

   // Output register
   always_comb begin
      out_peak_in = out_peak_ff;
      out_rms_in  = out_rms_ff;
      out_ovf_in  = out_ovf_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         out_peak_in  = hold_peak_ff;
         out_rms_in   = root;
         out_ovf_in   = hold_ovf_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         peak_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff       <= mag_in;
      last_ff      <= last_in;
      square_ff    <= square_in;
      hold_peak_ff <= hold_peak_in;
      hold_ovf_ff  <= hold_ovf_in;
      out_peak_ff  <= out_peak_in;
      out_rms_ff   <= out_rms_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.peak_level = out_peak_ff;
   assign rsp_chan.rms_level  = out_rms_ff;
   assign rsp_chan.overflow   = out_ovf_ff;

   // Checks
   `BPRM_ASSERT_NEXT(a_last_starts_engine, clock, reset, (state_ff == S_ADD) && last_ff, iter_status.busy, "engine not started at block end")
   `BPRM_ASSERT_IMPL(a_done_only_waiting, clock, reset, iter_status.done, state_ff == S_WAIT, "engine finished outside the wait state")
   `BPRM_ASSERT_IMPL(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_BLOCK_SAMPLES), "sample count above limit")
   `BPRM_ASSERT_IMPL(a_result_from_load, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT, "response raised without a load")

endmodule

`default_nettype wire
